>>> design/sfsm_pkg.sv
// shared types and constants of the sobel frame sharpness meter
package sfsm_pkg;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 2048;

  localparam int PIX_W    = 8;
  localparam int CFG_W    = 12;
  localparam int CFG_IDX_W = 2;
  localparam int THR_W    = 11;
  localparam int ENERGY_W = 15;
  localparam int LEVEL_W  = 2;
  localparam int SUM_W    = 37;
  localparam int CNT_W    = 22;
  localparam int SQ_W     = 21;
  localparam int RAD_W    = 29;
  localparam int ROOT_W   = 30;
  localparam int SQRT_STEPS = 15;
  localparam int DIV_STEPS  = 37;
  localparam int STEP_W     = 6;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SOFT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHARP  = 2'd3;

  localparam logic [CFG_W-1:0] WIDTH_RST  = 12'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 12'd480;
  localparam logic [THR_W-1:0] SOFT_RST   = 11'd15;
  localparam logic [THR_W-1:0] SHARP_RST  = 11'd30;

  localparam logic [LEVEL_W-1:0] LVL_SOFT   = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_NORMAL = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_SHARP  = 2'd2;

  typedef struct packed {
    logic load_px;
    logic calc;
    logic sqrt_step;
    logic acc;
    logic div_init;
    logic div_step;
    logic out_load;
  } sfsm_cmd_t;

  typedef struct packed {
    logic interior;
    logic frame_end;
    logic frame_end_r;
  } sfsm_sts_t;

endpackage

>>> design/sfsm_ctrl.sv
// sequencer of the sharpness meter: per-pixel steps, square root and frame-end divide
module sfsm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  sfsm_pkg::sfsm_sts_t  sts,
  output sfsm_pkg::sfsm_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_CALC, S_SQRT, S_ACC, S_DIVI, S_DIV, S_OUT
  } state_t;

  state_t                         state_r, state_nxt;
  logic [sfsm_pkg::STEP_W-1:0]    step_r, step_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic                           out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_px = 1'b1;
          state_nxt   = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc = 1'b1;
        step_nxt = '0;
        if (sts.interior) state_nxt = S_SQRT;
        else if (sts.frame_end) state_nxt = S_DIVI;
        else state_nxt = S_IDLE;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        step_nxt      = step_r + 1'b1;
        if (step_r == sfsm_pkg::STEP_W'(sfsm_pkg::SQRT_STEPS - 1)) state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = sts.frame_end_r ? S_DIVI : S_IDLE;
      end
      S_DIVI: begin
        cmd.div_init = 1'b1;
        step_nxt     = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == sfsm_pkg::STEP_W'(sfsm_pkg::DIV_STEPS - 1)) state_nxt = S_OUT;
      end
      S_OUT: begin
        // wait for the output register to drain before loading the frame result
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> design/sfsm_dp.sv
// datapath: config registers, line store, window, sobel, square root, accumulator, divider
module sfsm_dp #(
  parameter int MAX_WIDTH  = sfsm_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sfsm_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [sfsm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sfsm_pkg::CFG_W-1:0]          cfg_data,
  input  logic [sfsm_pkg::PIX_W-1:0]          in_luma_pixel,
  input  sfsm_pkg::sfsm_cmd_t                 cmd,
  output sfsm_pkg::sfsm_sts_t                 sts,
  output logic [sfsm_pkg::ENERGY_W-1:0]       out_edge_energy,
  output logic [sfsm_pkg::LEVEL_W-1:0]        out_sharpness_level
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int WSZA = $clog2(MAX_WIDTH + 1);
  localparam int HSZA = $clog2(MAX_HEIGHT + 1);
  localparam int WSZ  = (WSZA > sfsm_pkg::CFG_W) ? WSZA : sfsm_pkg::CFG_W;
  localparam int HSZ  = (HSZA > sfsm_pkg::CFG_W) ? HSZA : sfsm_pkg::CFG_W;
  localparam int PW   = sfsm_pkg::PIX_W;
  localparam int RMW  = sfsm_pkg::CNT_W + 1;

  // configuration
  logic [sfsm_pkg::CFG_W-1:0] width_r, height_r;
  logic [sfsm_pkg::THR_W-1:0] soft_r, sharp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= sfsm_pkg::WIDTH_RST;
      height_r <= sfsm_pkg::HEIGHT_RST;
      soft_r   <= sfsm_pkg::SOFT_RST;
      sharp_r  <= sfsm_pkg::SHARP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        sfsm_pkg::REG_WIDTH:  width_r  <= cfg_data;
        sfsm_pkg::REG_HEIGHT: height_r <= cfg_data;
        sfsm_pkg::REG_SOFT:   soft_r   <= cfg_data[sfsm_pkg::THR_W-1:0];
        sfsm_pkg::REG_SHARP:  sharp_r  <= cfg_data[sfsm_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  logic [WSZ-1:0] w_cfg, w_eff;
  logic [HSZ-1:0] h_cfg, h_eff;
  assign w_cfg = WSZ'(width_r);
  assign h_cfg = HSZ'(height_r);
  assign w_eff = (w_cfg < WSZ'(3)) ? WSZ'(3) : ((w_cfg > WSZ'(MAX_WIDTH)) ? WSZ'(MAX_WIDTH) : w_cfg);
  assign h_eff = (h_cfg < HSZ'(3)) ? HSZ'(3) :
                 ((h_cfg > HSZ'(MAX_HEIGHT)) ? HSZ'(MAX_HEIGHT) : h_cfg);

  // positions
  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic          line_end, frame_end, fe_r;

  assign line_end  = (WSZ'(col_r) + WSZ'(1)) >= w_eff;
  assign frame_end = line_end && ((HSZ'(row_r) + HSZ'(1)) >= h_eff);

  // line store: upper byte row y-2, lower byte row y-1
  logic [2*PW-1:0] line_mem [MAX_WIDTH];
  logic [2*PW-1:0] rd_r;
  logic [PW-1:0]   bot_r;
  logic [PW-1:0]   top, mid;

  assign top = rd_r[2*PW-1:PW];
  assign mid = rd_r[PW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load_px) begin
      rd_r  <= line_mem[col_r];
      bot_r <= in_luma_pixel;
    end
    if (cmd.calc) line_mem[col_r] <= {mid, bot_r};
  end

  // window: left column l0..l2, centre c0..c2
  logic [PW-1:0] win_r [6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) win_r[i] <= '0;
    end else if (cmd.calc) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= top;
      win_r[4] <= mid;
      win_r[5] <= bot_r;
    end
  end

  // sobel
  logic signed [11:0] gx, gy;
  logic [sfsm_pkg::SQ_W:0] gx2, gy2;
  logic [sfsm_pkg::SQ_W-1:0] sq;

  always_comb begin
    gx = (12'(top) - 12'(win_r[0])) + 12'(2 * (12'(mid) - 12'(win_r[1])))
       + (12'(bot_r) - 12'(win_r[2]));
    gy = (12'(win_r[2]) - 12'(win_r[0])) + 12'(2 * (12'(win_r[5]) - 12'(win_r[3])))
       + (12'(bot_r) - 12'(top));
    gx2 = (sfsm_pkg::SQ_W+1)'(gx * gx);
    gy2 = (sfsm_pkg::SQ_W+1)'(gy * gy);
    sq  = sfsm_pkg::SQ_W'(gx2 + gy2);
  end

  // bit-pair square root of sq*256, one step a cycle
  logic [sfsm_pkg::RAD_W-1:0]  rad_r;
  logic [sfsm_pkg::ROOT_W-1:0] root_r, bit_r, trial;

  assign trial = root_r + bit_r;

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      rad_r  <= {sq, 8'd0};
      root_r <= '0;
      bit_r  <= sfsm_pkg::ROOT_W'(1) << (2 * (sfsm_pkg::SQRT_STEPS - 1));
    end else if (cmd.sqrt_step) begin
      if (sfsm_pkg::ROOT_W'(rad_r) >= trial) begin
        rad_r  <= sfsm_pkg::RAD_W'(sfsm_pkg::ROOT_W'(rad_r) - trial);
        root_r <= (root_r >> 1) + bit_r;
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  // positions, sums and divider
  logic [sfsm_pkg::SUM_W-1:0] sum_r, q_r;
  logic [sfsm_pkg::CNT_W-1:0] cnt_r, dvs_r;
  logic [RMW-1:0]             rem_r, rem_sh;
  logic                       rem_ge;

  assign rem_sh = {rem_r[RMW-2:0], q_r[sfsm_pkg::SUM_W-1]};
  assign rem_ge = rem_sh >= RMW'(dvs_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      fe_r  <= 1'b0;
      sum_r <= '0;
      cnt_r <= '0;
    end else begin
      if (cmd.calc) begin
        fe_r <= frame_end;
        if (!line_end) begin
          col_r <= col_r + 1'b1;
        end else begin
          col_r <= '0;
          row_r <= frame_end ? '0 : row_r + 1'b1;
        end
      end
      if (cmd.acc) begin
        sum_r <= sum_r + sfsm_pkg::SUM_W'(root_r);
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.div_init) begin
        sum_r <= '0;
        cnt_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      q_r   <= sum_r;
      dvs_r <= cnt_r;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= rem_ge ? rem_sh - RMW'(dvs_r) : rem_sh;
      q_r   <= {q_r[sfsm_pkg::SUM_W-2:0], rem_ge};
    end
  end

  // mean, saturated to the output range, and level decision
  logic [sfsm_pkg::ENERGY_W-1:0] mean;
  logic [sfsm_pkg::ENERGY_W-1:0] soft_x16, sharp_x16;

  always_comb begin
    if (dvs_r == '0) mean = '0;
    else if (q_r[sfsm_pkg::SUM_W-1:sfsm_pkg::ENERGY_W] != '0) mean = '1;
    else mean = q_r[sfsm_pkg::ENERGY_W-1:0];
    soft_x16  = {soft_r, 4'd0};
    sharp_x16 = {sharp_r, 4'd0};
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_edge_energy <= mean;
      if (mean < soft_x16) out_sharpness_level <= sfsm_pkg::LVL_SOFT;
      else if (mean < sharp_x16) out_sharpness_level <= sfsm_pkg::LVL_NORMAL;
      else out_sharpness_level <= sfsm_pkg::LVL_SHARP;
    end
  end

  assign sts.interior    = (col_r >= CW'(2)) && (row_r >= RW'(2));
  assign sts.frame_end   = frame_end;
  assign sts.frame_end_r = fe_r;

endmodule

>>> design/sobel_frame_sharpness_meter.sv
// Sobel frame sharpness meter: measures mean gradient magnitude of a luma frame.
// Pixels enter on in_luma_pixel with in_valid/in_ready, in raster order, for a
// frame of cfg_data sizes written through cfg_we/cfg_index (width, height, soft
// and sharp thresholds). One item is handled at a time: an interior pixel, unlike
// a border pixel, also passes through the 15-step bit-pair square root unit that
// works each magnitude. After the last pixel of the frame a 37-step restoring
// divider forms the mean, and the result is then loaded into the output register
// and out_valid rises; one result per frame.
// The output register parts the two sides: while a result waits on out_ready
// the next frame's pixels are still taken; only a further frame end waits
// for it to drain.
// Synchronous active-low reset restores the register defaults (640 x 480,
// thresholds 15 and 30), clears positions, sums and the window, and drops
// out_valid. Line store contents are not cleared; every entry is written in
// the first two lines of a frame before it feeds an interior pixel.
module sobel_frame_sharpness_meter #(
  parameter int MAX_WIDTH  = sfsm_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sfsm_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [sfsm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sfsm_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [sfsm_pkg::PIX_W-1:0]          in_luma_pixel,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sfsm_pkg::ENERGY_W-1:0]       out_edge_energy,
  output logic [sfsm_pkg::LEVEL_W-1:0]        out_sharpness_level
);

  sfsm_pkg::sfsm_cmd_t cmd;
  sfsm_pkg::sfsm_sts_t sts;

  sfsm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sfsm_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_luma_pixel       (in_luma_pixel),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_edge_energy     (out_edge_energy),
    .out_sharpness_level (out_sharpness_level)
  );

  // one pixel in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("pixel taken while previous one still in work");

  a_level_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_sharpness_level != 2'd3)
    else $error("illegal sharpness level");

  // a result only appears after the frame-end divide, never straight from idle
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result raised without frame-end processing");

endmodule
